// ===== design/quaternion_multiply_rotate_top_assert.svh =====
// Assertion macros for the quaternion multiply/rotate unit.
// Included by the top level; no other dependencies.
`ifndef QUATERNION_MULTIPLY_ROTATE_TOP_ASSERT_SVH
`define QUATERNION_MULTIPLY_ROTATE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define QMR_CHK_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define QMR_CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/qmr_pkg.sv =====
// Shared types and constant tables for the quaternion multiply/rotate unit.
// No dependencies.
package qmr_pkg;

    // Component lanes of a quaternion
    typedef logic [1:0] lane_t;

    localparam lane_t QX = 2'd0;
    localparam lane_t QY = 2'd1;
    localparam lane_t QZ = 2'd2;
    localparam lane_t QW = 2'd3;

    // Control that travels with each beat down the pipeline
    typedef struct packed {
        logic valid;
        logic kind;
        logic sat;
    } ctl_t;

    // Item kinds
    localparam logic KIND_PRODUCT = 1'b0;
    localparam logic KIND_ROTATE  = 1'b1;

    // Hamilton product terms: lane l, term k uses lhs[LHS_IDX[l][k]] * rhs[RHS_IDX[l][k]]
    localparam lane_t LHS_IDX [4][4] = '{
        '{QX, QW, QY, QZ},
        '{QY, QW, QZ, QX},
        '{QZ, QW, QX, QY},
        '{QW, QX, QY, QZ}
    };

    localparam lane_t RHS_IDX [4][4] = '{
        '{QW, QX, QZ, QY},
        '{QW, QY, QX, QZ},
        '{QW, QZ, QY, QX},
        '{QW, QX, QY, QZ}
    };

    // Bit k set: term k is subtracted
    localparam logic [3:0] TERM_NEG [4] = '{
        4'b1000,
        4'b1000,
        4'b1000,
        4'b1110
    };

endpackage

// ===== design/qmr_prod.sv =====
// Product stage: the sixteen partial products of one Hamilton product, registered.
// Depends on qmr_pkg.
module qmr_prod #(
    parameter int W = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  qmr_pkg::ctl_t        ctl_in,
    input  logic signed [W:0]    lhs [4],
    input  logic signed [W-1:0]  rhs [4],
    output qmr_pkg::ctl_t        ctl_out,
    output logic signed [2*W:0]  prod [4][4]
);

    localparam int PW = 2 * W + 1;

    qmr_pkg::ctl_t        ctl_reg;
    logic signed [PW-1:0] prod_reg  [4][4];
    logic signed [PW-1:0] prod_next [4][4];

    // Partial products, unsigned-term order per lane; operands widened first
    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                prod_next[l][k] = PW'(lhs[qmr_pkg::LHS_IDX[l][k]])
                                  * PW'(rhs[qmr_pkg::RHS_IDX[l][k]]);
            end
        end
    end

    // Control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    // Product registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign ctl_out = ctl_reg;
    assign prod    = prod_reg;

endmodule

// ===== design/qmr_round.sv =====
// Sum stage: sums four terms per lane, rounds to nearest, saturates; or bypass.
// Depends on qmr_pkg.
module qmr_round #(
    parameter int W = 16,
    parameter int F = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  qmr_pkg::ctl_t        ctl_in,
    input  logic signed [2*W:0]  prod [4][4],
    input  logic signed [W-1:0]  pass_q [4],
    input  logic                 bypass,
    input  logic                 w_en,
    output qmr_pkg::ctl_t        ctl_out,
    output logic signed [W-1:0]  q_out [4]
);

    localparam int SW = (2 * W + 4 > F + 2) ? 2 * W + 4 : F + 2;
    localparam logic [SW-1:0] HALF = {{(SW-1){1'b0}}, 1'b1} << (F - 1);
    localparam logic [W-1:0]  SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  SAT_MIN = {1'b1, {(W-1){1'b0}}};

    qmr_pkg::ctl_t       ctl_reg;
    qmr_pkg::ctl_t       ctl_next;
    logic signed [W-1:0] q_reg  [4];
    logic signed [W-1:0] q_next [4];

    // Exact sum, half-LSB round, floor shift, clip
    always_comb
    begin
        logic signed [SW-1:0] acc;
        logic signed [SW-1:0] ext;
        logic signed [SW-1:0] shr;
        logic                 fits;
        logic [3:0]           lane_sat;
        logic [3:0]           lane_use;
        logic signed [W-1:0]  lane_q [4];

        lane_sat = '0;
        lane_use = {w_en, 3'b111};
        for (int l = 0; l < 4; l++)
        begin
            acc = '0;
            for (int k = 0; k < 4; k++)
            begin
                ext = SW'(prod[l][k]);
                if (qmr_pkg::TERM_NEG[l][k])
                    acc = acc - ext;
                else
                    acc = acc + ext;
            end
            shr  = (acc + $signed(HALF)) >>> F;
            fits = (&shr[SW-1:W-1]) || !(|shr[SW-1:W-1]);
            if (fits)
                lane_q[l] = shr[W-1:0];
            else if (shr[SW-1])
                lane_q[l] = SAT_MIN;
            else
                lane_q[l] = SAT_MAX;
            lane_sat[l] = !fits;
        end

        ctl_next = ctl_in;
        if (bypass)
        begin
            q_next = pass_q;
        end
        else
        begin
            for (int l = 0; l < 4; l++)
            begin
                q_next[l] = lane_use[l] ? lane_q[l] : '0;
            end
            ctl_next.sat = ctl_in.sat | (|(lane_sat & lane_use));
        end
    end

    // Control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign ctl_out = ctl_reg;
    assign q_out   = q_reg;

endmodule

// ===== design/quaternion_multiply_rotate_top.sv =====
// Quaternion product / vector rotation unit, Q(WORD_BITS-FRAC_BITS).FRAC_BITS fixed point.
// Result strobe (done) follows a taken start through four register stages: product,
// sum/round, product, sum/round.
// Throughput: one beat per cycle; busy is always low and nothing stalls.
// Reset (rst_n low, async) clears the valid bits of all stages; data registers are not reset.
// Depends on qmr_pkg, qmr_prod, qmr_round, quaternion_multiply_rotate_top_assert.svh.
`include "quaternion_multiply_rotate_top_assert.svh"

module quaternion_multiply_rotate_top #(
    parameter int WORD_BITS = 16,
    parameter int FRAC_BITS = 14
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        kind,
    input  logic signed [WORD_BITS-1:0] a_x,
    input  logic signed [WORD_BITS-1:0] a_y,
    input  logic signed [WORD_BITS-1:0] a_z,
    input  logic signed [WORD_BITS-1:0] a_w,
    input  logic signed [WORD_BITS-1:0] b_x,
    input  logic signed [WORD_BITS-1:0] b_y,
    input  logic signed [WORD_BITS-1:0] b_z,
    input  logic signed [WORD_BITS-1:0] b_w,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] r_x,
    output logic signed [WORD_BITS-1:0] r_y,
    output logic signed [WORD_BITS-1:0] r_z,
    output logic signed [WORD_BITS-1:0] r_w,
    output logic                        saturated
);

    localparam int W = WORD_BITS;

    qmr_pkg::ctl_t       ctl0;
    qmr_pkg::ctl_t       ctl1;
    qmr_pkg::ctl_t       ctl2;
    qmr_pkg::ctl_t       ctl3;
    qmr_pkg::ctl_t       ctl4;
    logic signed [W:0]   lhs1 [4];
    logic signed [W-1:0] rhs1 [4];
    logic signed [W:0]   lhs3 [4];
    logic signed [2*W:0] prod1 [4][4];
    logic signed [2*W:0] prod3 [4][4];
    logic signed [W-1:0] a_in [4];
    logic signed [W-1:0] a1_reg [4];
    logic signed [W-1:0] a2_reg [4];
    logic signed [W-1:0] q2 [4];
    logic signed [W-1:0] q3_reg [4];
    logic signed [W-1:0] q4 [4];
    logic signed [W-1:0] zero_q [4];
    logic                accept;

    // The pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Entry control beat
    always_comb
    begin
        ctl0.valid = accept;
        ctl0.kind  = kind;
        ctl0.sat   = 1'b0;
    end

    // Operand select: A*B, or conj(A)*(b,0) for rotation
    always_comb
    begin
        a_in[qmr_pkg::QX] = a_x;
        a_in[qmr_pkg::QY] = a_y;
        a_in[qmr_pkg::QZ] = a_z;
        a_in[qmr_pkg::QW] = a_w;
        for (int i = 0; i < 4; i++)
        begin
            lhs1[i]   = (W+1)'(a_in[i]);
            zero_q[i] = '0;
        end
        rhs1[qmr_pkg::QX] = b_x;
        rhs1[qmr_pkg::QY] = b_y;
        rhs1[qmr_pkg::QZ] = b_z;
        rhs1[qmr_pkg::QW] = b_w;
        if (kind == qmr_pkg::KIND_ROTATE)
        begin
            // conjugate kept one bit wider, never clipped
            lhs1[qmr_pkg::QX] = -(W+1)'(a_x);
            lhs1[qmr_pkg::QY] = -(W+1)'(a_y);
            lhs1[qmr_pkg::QZ] = -(W+1)'(a_z);
            rhs1[qmr_pkg::QW] = '0;
        end
    end

    // Stage 1: first product
    qmr_prod #(
        .W (W)
    ) u_prod1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl0),
        .lhs     (lhs1),
        .rhs     (rhs1),
        .ctl_out (ctl1),
        .prod    (prod1)
    );

    // Stage 2: round first product to word format
    qmr_round #(
        .W (W),
        .F (FRAC_BITS)
    ) u_round2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl1),
        .prod    (prod1),
        .pass_q  (zero_q),
        .bypass  (1'b0),
        .w_en    (1'b1),
        .ctl_out (ctl2),
        .q_out   (q2)
    );

    // A delayed to meet stage 3; stage 2 result kept for the product bypass
    always_ff @(posedge clk)
    begin
        a1_reg <= a_in;
        a2_reg <= a1_reg;
        q3_reg <= q2;
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            lhs3[i] = (W+1)'(q2[i]);
        end
    end

    // Stage 3: T*A
    qmr_prod #(
        .W (W)
    ) u_prod3 (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl2),
        .lhs     (lhs3),
        .rhs     (a2_reg),
        .ctl_out (ctl3),
        .prod    (prod3)
    );

    // Stage 4: round rotation result, w not formed; plain products pass through
    qmr_round #(
        .W (W),
        .F (FRAC_BITS)
    ) u_round4 (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl3),
        .prod    (prod3),
        .pass_q  (q3_reg),
        .bypass  (ctl3.kind == qmr_pkg::KIND_PRODUCT),
        .w_en    (1'b0),
        .ctl_out (ctl4),
        .q_out   (q4)
    );

    // Result beat
    assign done      = ctl4.valid;
    assign r_x       = q4[qmr_pkg::QX];
    assign r_y       = q4[qmr_pkg::QY];
    assign r_z       = q4[qmr_pkg::QZ];
    assign r_w       = q4[qmr_pkg::QW];
    assign saturated = ctl4.sat;

    // Checks
    `QMR_CHK_SAME(a_done_latency, clk, rst_n, done, $past(accept, 4), "result without matching start")
    `QMR_CHK_SAME(a_rot_w_zero, clk, rst_n, done && (ctl4.kind == qmr_pkg::KIND_ROTATE), r_w == '0, "rotation result has nonzero w")
    `QMR_CHK_NEXT(a_stage_flow, clk, rst_n, ctl1.valid, ctl2.valid && (ctl2.kind == $past(ctl1.kind)), "beat lost between stages 1 and 2")

endmodule
